/* hdl/rks_pkg.sv */
// Shared types and constants for the range k-th smallest persistent tree unit.
`default_nettype none
package rks_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_QUERY = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_AP_ROOT,
    S_AP_RD,
    S_AP_WR,
    S_AP_LEAF,
    S_Q_ROOTA,
    S_Q_ROOTB,
    S_Q_RDNODE,
    S_Q_RDKID,
    S_Q_STEP,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic check;
    logic ap_root;
    logic ap_rd;
    logic ap_wr;
    logic ap_leaf;
    logic q_roota;
    logic q_rootb;
    logic q_rdnode;
    logic q_rdkid;
    logic q_step;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_query;
    logic bad;
    logic last_level;
    logic leaf;        // append walk has passed the last value bit
  } sts_t;

endpackage
`default_nettype wire

/* hdl/rks_if.sv */
// Valid/ready channel interface carrying a generic payload.
`default_nettype none
interface rks_if #(parameter int W = 8) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/rks_ctrl.sv */
// Controller state machine sequencing appends and queries.
`default_nettype none
module rks_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic          out_busy,
  input  wire rks_pkg::sts_t sts,
  output rks_pkg::cmd_t      cmd,
  output logic               idle
);
  rks_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rks_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    idle = 1'b0;
    unique case (state_r)
      rks_pkg::S_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = rks_pkg::S_CHECK;
        end
      end
      rks_pkg::S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.bad) state_nxt = rks_pkg::S_DONE;
        else if (sts.is_query) state_nxt = rks_pkg::S_Q_ROOTA;
        else state_nxt = rks_pkg::S_AP_ROOT;
      end
      rks_pkg::S_AP_ROOT: begin
        cmd.ap_root = 1'b1;
        state_nxt = rks_pkg::S_AP_RD;
      end
      rks_pkg::S_AP_RD: begin
        // one extra read after the last level fetches the old leaf tally
        cmd.ap_rd = 1'b1;
        state_nxt = sts.leaf ? rks_pkg::S_AP_LEAF : rks_pkg::S_AP_WR;
      end
      rks_pkg::S_AP_WR: begin
        cmd.ap_wr = 1'b1;
        state_nxt = rks_pkg::S_AP_RD;
      end
      rks_pkg::S_AP_LEAF: begin
        cmd.ap_leaf = 1'b1;
        state_nxt = rks_pkg::S_DONE;
      end
      rks_pkg::S_Q_ROOTA: begin
        cmd.q_roota = 1'b1;
        state_nxt = rks_pkg::S_Q_ROOTB;
      end
      rks_pkg::S_Q_ROOTB: begin
        cmd.q_rootb = 1'b1;
        state_nxt = rks_pkg::S_Q_RDNODE;
      end
      rks_pkg::S_Q_RDNODE: begin
        cmd.q_rdnode = 1'b1;
        state_nxt = rks_pkg::S_Q_RDKID;
      end
      rks_pkg::S_Q_RDKID: begin
        cmd.q_rdkid = 1'b1;
        state_nxt = rks_pkg::S_Q_STEP;
      end
      rks_pkg::S_Q_STEP: begin
        cmd.q_step = 1'b1;
        state_nxt = sts.last_level ? rks_pkg::S_DONE : rks_pkg::S_Q_RDNODE;
      end
      rks_pkg::S_DONE: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_nxt = rks_pkg::S_IDLE;
        end
      end
      default: state_nxt = rks_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* hdl/rks_dpath.sv */
// Datapath: node and root memories, append path copy, dual-version descent.
`default_nettype none
module rks_dpath #(
  parameter int MAX_ELEMS  = 1024,
  parameter int VALUE_BITS = 16,
  parameter int NODE_SLOTS = 32768
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rks_pkg::cmd_t cmd,
  input  wire logic          in_func,
  input  wire logic [15:0]   in_new_value,
  input  wire logic [10:0]   in_first_pos,
  input  wire logic [10:0]   in_last_pos,
  input  wire logic [10:0]   in_rank_pos,
  output rks_pkg::sts_t      sts,
  output logic [15:0]        res_answer,
  output logic [1:0]         res_status
);
  localparam int NW = $clog2(NODE_SLOTS);
  localparam int CW = $clog2(MAX_ELEMS + 1);
  localparam int RD = MAX_ELEMS + 1;
  localparam int RW = $clog2(RD);
  localparam int LW = $clog2(VALUE_BITS + 1);
  localparam int IW = $clog2(VALUE_BITS);
  localparam int TW = CW;

  // node memory: one word holds left, right, tally
  localparam int MW = 2 * NW + TW;
  logic [MW-1:0] node_mem [NODE_SLOTS];
  logic [NW-1:0] root_mem [RD];

  logic                  func_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [10:0]           x_r, y_r, p_r;
  logic [CW-1:0]         cnt_r;
  logic [NW:0]           free_r;
  logic [LW-1:0]         lvl_r;
  logic [NW-1:0]         a_r, b_r, prev_r, cur_r;
  logic [CW-1:0]         k_r;
  logic [VALUE_BITS-1:0] ans_r;
  logic [1:0]            stat_r;
  logic [NW-1:0]         al_r, ar_r, bl_r, br_r;
  logic [MW-1:0]         rd_r, rd2_r;
  logic [NW-1:0]         root_rd_r;
  logic                  nm_zero_r, nm2_zero_r, rt_zero_r;

  // read data fields; null slots read as zero
  logic [MW-1:0] rdz, rd2z;
  logic [NW-1:0] rd_l, rd_r_c, root_nd;
  logic [TW-1:0] rd_t, ldiff_z;
  logic [IW-1:0] bit_idx;
  logic          bit_v;
  logic          bad_c;
  logic          lvl0;
  logic [NW:0]   need;

  logic          nm_we;
  logic [NW-1:0] nm_wa;
  logic [MW-1:0] nm_wd;
  logic [NW-1:0] nm_ra, nm2_ra;
  logic          nm_re;
  logic [RW-1:0] rt_ra;

  assign rdz     = nm_zero_r  ? '0 : rd_r;
  assign rd2z    = nm2_zero_r ? '0 : rd2_r;
  assign rd_l    = rdz[MW-1 -: NW];
  assign rd_r_c  = rdz[MW-NW-1 -: NW];
  assign rd_t    = rdz[TW-1:0];
  assign ldiff_z = rd2z[TW-1:0] - rd_t;
  assign root_nd = rt_zero_r ? '0 : root_rd_r;
  assign lvl0    = (lvl_r == '0);
  assign bit_idx = IW'(VALUE_BITS - 1) - lvl_r[IW-1:0];
  assign bit_v   = val_r[bit_idx];
  assign need    = free_r + (NW+1)'(VALUE_BITS + 1);

  always_comb begin
    if (func_r == rks_pkg::FUNC_QUERY)
      bad_c = (x_r == 11'd0) || (y_r < x_r) || (32'(y_r) > 32'(cnt_r)) ||
              (p_r < x_r) || (p_r > y_r);
    else
      bad_c = (32'(cnt_r) >= MAX_ELEMS) || (32'(need) > NODE_SLOTS);
  end

  assign sts.is_query   = func_r;
  assign sts.bad        = bad_c;
  assign sts.last_level = (32'(lvl_r) == VALUE_BITS - 1);
  assign sts.leaf       = (32'(lvl_r) == VALUE_BITS);

  // first level takes its node address straight from the root read
  always_comb begin
    nm_we = 1'b0;
    nm_wa = cur_r;
    nm_wd = '0;
    nm_re = 1'b0;
    nm_ra = prev_r;
    if (cmd.ap_rd) begin
      nm_re = 1'b1;
      nm_ra = lvl0 ? root_nd : prev_r;
    end
    if (cmd.ap_wr) begin
      nm_we = 1'b1;
      if (bit_v)
        nm_wd = {rd_l, cur_r + NW'(1), rd_t + TW'(1)};
      else
        nm_wd = {cur_r + NW'(1), rd_r_c, rd_t + TW'(1)};
    end
    if (cmd.ap_leaf) begin
      nm_we = 1'b1;
      nm_wd = {{(2*NW){1'b0}}, rd_t + TW'(1)};
    end
    if (cmd.q_rdnode) begin
      nm_re = 1'b1;
      nm_ra = a_r;
    end
    if (cmd.q_rdkid) begin
      nm_re = 1'b1;
      nm_ra = rd_l;
    end
  end

  always_ff @(posedge clk) begin
    if (nm_we) node_mem[nm_wa] <= nm_wd;
    if (nm_re) rd_r <= node_mem[nm_ra];
    nm_zero_r <= (nm_ra == '0);
  end

  // second read port for version b
  assign nm2_ra = cmd.q_rdkid ? rd2z[MW-1 -: NW] : (lvl0 ? root_nd : b_r);
  always_ff @(posedge clk) begin
    if (cmd.q_rdnode || cmd.q_rdkid) rd2_r <= node_mem[nm2_ra];
    nm2_zero_r <= (nm2_ra == '0);
  end

  // root memory: entry zero is null, others written before use
  assign rt_ra = cmd.ap_root ? RW'(cnt_r) :
                 cmd.q_roota ? RW'(x_r - 11'd1) : RW'(y_r);
  always_ff @(posedge clk) begin
    if (cmd.ap_leaf) root_mem[RW'(cnt_r + CW'(1))] <= free_r[NW-1:0];
    root_rd_r <= root_mem[rt_ra];
    rt_zero_r <= (rt_ra == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      free_r <= (NW+1)'(1);
      stat_r <= '0;
    end else begin
      if (cmd.check && bad_c)
        stat_r <= func_r ? 2'(rks_pkg::ST_BAD_QUERY) : 2'(rks_pkg::ST_FULL);
      else if (cmd.check)
        stat_r <= 2'(rks_pkg::ST_OK);
      if (cmd.ap_leaf) begin
        cnt_r  <= cnt_r + CW'(1);
        free_r <= need;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      val_r  <= VALUE_BITS'(in_new_value);
      x_r    <= in_first_pos;
      y_r    <= in_last_pos;
      p_r    <= in_rank_pos;
      ans_r  <= '0;
      lvl_r  <= '0;
    end
    if (cmd.check) begin
      cur_r <= free_r[NW-1:0];
      k_r   <= CW'(p_r - x_r + 11'd1);
    end
    if (cmd.q_rootb) a_r <= root_nd;
    if (cmd.ap_wr) begin
      prev_r <= bit_v ? rd_r_c : rd_l;
      cur_r  <= cur_r + NW'(1);
      lvl_r  <= lvl_r + LW'(1);
    end
    if (cmd.q_rdkid) begin
      al_r <= rd_l;
      ar_r <= rd_r_c;
      bl_r <= rd2z[MW-1 -: NW];
      br_r <= rd2z[MW-NW-1 -: NW];
    end
    if (cmd.q_step) begin
      if (k_r <= ldiff_z) begin
        a_r <= al_r;
        b_r <= bl_r;
      end else begin
        k_r <= k_r - ldiff_z;
        ans_r[bit_idx] <= 1'b1;
        a_r <= ar_r;
        b_r <= br_r;
      end
      if (!sts.last_level) lvl_r <= lvl_r + LW'(1);
    end
  end

  assign res_answer = (stat_r == 2'(rks_pkg::ST_OK) && func_r) ? 16'(ans_r) : 16'd0;
  assign res_status = stat_r;
endmodule
`default_nettype wire

/* hdl/range_kth_smallest_persistent_tree_unit.sv */
// Range k-th smallest over a persistent count tree: one result per item.
// One request at a time: a request is taken only in the idle state, and the next
// one can be taken in the same cycle that the result posts, while it still waits in
// the output register. Each value level is walked through a node read and a node
// write on append, and through a node read, a child read and a step on query.
// Result held in an output register until taken. Reset clears element count and
// node allocator; no memory clearing pass.
`default_nettype none
module range_kth_smallest_persistent_tree_unit #(
  parameter int MAX_ELEMS  = 1024,
  parameter int VALUE_BITS = 16,
  parameter int NODE_SLOTS = 32768
) (
  input wire logic clk,
  input wire logic rst_n,
  rks_if.sink      in_ch,
  rks_if.source    out_ch
);
  rks_pkg::cmd_t cmd;
  rks_pkg::sts_t sts;
  logic idle;
  logic [15:0] ans;
  logic [1:0]  st;
  logic        ov_r;
  logic [17:0] od_r;

  assign in_ch.ready = idle;

  rks_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_ch.valid && in_ch.ready),
    .out_busy(ov_r && !out_ch.ready),
    .sts(sts), .cmd(cmd), .idle(idle)
  );

  rks_dpath #(.MAX_ELEMS(MAX_ELEMS), .VALUE_BITS(VALUE_BITS),
              .NODE_SLOTS(NODE_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_func(in_ch.data[49]), .in_new_value(in_ch.data[48:33]),
    .in_first_pos(in_ch.data[32:22]), .in_last_pos(in_ch.data[21:11]),
    .in_rank_pos(in_ch.data[10:0]),
    .sts(sts), .res_answer(ans), .res_status(st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.finish) ov_r <= 1'b1;
    else if (out_ch.ready) ov_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.finish) od_r <= {ans, st};
  end
  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;

  a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(ov_r && !out_ch.ready)) else $error("overwrite of pending result");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("accepted while busy");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data[1:0] != 2'd3)) else $error("bad status code");
endmodule
`default_nettype wire

/* sim/rks_tb_sb.sv */
// Scoreboard: order-statistic predictor and queue of expected responses.
`timescale 1ns / 1ps
class rks_scoreboard;
  typedef struct {
    logic [15:0] answer;
    logic [1:0]  status;
  } response_t;

  response_t   expected_q[$];
  logic [15:0] seq_values[$];
  int          errors;
  int          max_elems;

  function new(int max_elems_i);
    max_elems = max_elems_i;
    errors    = 0;
  endfunction

  function int stored();
    return seq_values.size();
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // k-th smallest over positions x..y (one based); same as the tree walk
  function logic [15:0] kth_in_range(int x, int y, int k);
    logic [15:0] window[$];
    for (int i = x; i <= y; i++) window.push_back(seq_values[i-1]);
    window.sort();
    return window[k-1];
  endfunction

  function void note_request(logic func, logic [15:0] value, logic [10:0] x,
                             logic [10:0] y, logic [10:0] p);
    response_t r;
    r.answer = '0;
    if (func == rks_pkg::FUNC_APPEND) begin
      if (seq_values.size() >= max_elems) begin
        r.status = rks_pkg::ST_FULL;
      end else begin
        seq_values.push_back(value);
        r.status = rks_pkg::ST_OK;
      end
    end else if (x == 0 || y < x || y > seq_values.size() || p < x || p > y) begin
      r.status = rks_pkg::ST_BAD_QUERY;
    end else begin
      r.status = rks_pkg::ST_OK;
      r.answer = kth_in_range(x, y, p - x + 1);
    end
    expected_q.push_back(r);
  endfunction

  function void check_response(logic [15:0] answer, logic [1:0] status);
    response_t r;
    if (expected_q.size() == 0) begin
      $error("unexpected response answer=%0d status=%0d", answer, status);
      errors++;
      return;
    end
    r = expected_q.pop_front();
    if (answer !== r.answer) begin
      $error("answer: expected %0d actual %0d", r.answer, answer);
      errors++;
    end
    if (status !== r.status) begin
      $error("status: expected %0d actual %0d", r.status, status);
      errors++;
    end
  endfunction
endclass

/* sim/range_kth_smallest_persistent_tree_unit_tb.sv */
// Testbench top: drives appends and range rank queries, checks each response.
`timescale 1ns / 1ps
module range_kth_smallest_persistent_tree_unit_tb;

  localparam int MAX_ELEMS   = 1024;
  localparam int IN_W        = 50;
  localparam int OUT_W       = 18;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst_n;
  int   in_idle_pct;
  int   out_idle_pct;
  int   hold_off;
  int   cycles;

  rks_if #(.W(IN_W))  in_ch  (.clk(clk));
  rks_if #(.W(OUT_W)) out_ch (.clk(clk));

  range_kth_smallest_persistent_tree_unit #(
    .MAX_ELEMS (MAX_ELEMS),
    .VALUE_BITS(16),
    .NODE_SLOTS(32768)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  rks_scoreboard order_sb = new(MAX_ELEMS);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // response side: check, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      order_sb.check_response(out_ch.data[17:2], out_ch.data[1:0]);
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off = hold_off - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic send_request(logic func, logic [15:0] value, logic [10:0] x,
                              logic [10:0] y, logic [10:0] p);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= {func, value, x, y, p};
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    order_sb.note_request(func, value, x, y, p);
    if ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(6, 1);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (order_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_query();
    int n, x, y, p;
    n = order_sb.stored();
    if (n == 0 || $urandom_range(99) < 12) begin
      // noise: raw fields, mostly malformed
      send_request(rks_pkg::FUNC_QUERY, 16'($urandom), 11'($urandom_range(2047)),
                   11'($urandom_range(2047)), 11'($urandom_range(2047)));
    end else begin
      if ($urandom_range(3) == 0) begin
        x = 1;
        y = n;
      end else begin
        x = $urandom_range(n, 1);
        y = $urandom_range(n, x);
      end
      p = $urandom_range(y, x);
      send_request(rks_pkg::FUNC_QUERY, 16'($urandom), 11'(x), 11'(y), 11'(p));
    end
  endtask

  task automatic random_append();
    send_request(rks_pkg::FUNC_APPEND, 16'($urandom), 11'($urandom), 11'($urandom),
                 11'($urandom));
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 58)
        random_append();
      else
        random_query();
    end
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_off     = 0;
    @(posedge rst_n);
    @(posedge clk);
    // directed
    send_request(rks_pkg::FUNC_QUERY, 16'h0, 11'd1, 11'd1, 11'd1);       // empty store
    send_request(rks_pkg::FUNC_APPEND, 16'h0000, 11'd0, 11'd0, 11'd0);
    send_request(rks_pkg::FUNC_APPEND, 16'hFFFF, 11'h7FF, 11'h7FF, 11'h7FF);
    send_request(rks_pkg::FUNC_APPEND, 16'h8000, 11'd0, 11'd0, 11'd0);
    send_request(rks_pkg::FUNC_APPEND, 16'h0001, 11'd0, 11'd0, 11'd0);
    send_request(rks_pkg::FUNC_APPEND, 16'hFFFF, 11'd0, 11'd0, 11'd0);
    send_request(rks_pkg::FUNC_APPEND, 16'h7FFF, 11'd0, 11'd0, 11'd0);
    for (int p = 1; p <= 6; p++)
      send_request(rks_pkg::FUNC_QUERY, 16'h0, 11'd1, 11'd6, 11'(p));
    send_request(rks_pkg::FUNC_QUERY, 16'h0, 11'd3, 11'd3, 11'd3);       // single element
    send_request(rks_pkg::FUNC_QUERY, 16'h0, 11'd2, 11'd5, 11'd4);
    send_request(rks_pkg::FUNC_QUERY, 16'h0, 11'd0, 11'd3, 11'd1);       // first_pos zero
    send_request(rks_pkg::FUNC_QUERY, 16'h0, 11'd4, 11'd2, 11'd3);       // reversed range
    send_request(rks_pkg::FUNC_QUERY, 16'h0, 11'd1, 11'd7, 11'd2);       // past stored count
    send_request(rks_pkg::FUNC_QUERY, 16'h0, 11'd3, 11'd5, 11'd2);       // rank below range
    send_request(rks_pkg::FUNC_QUERY, 16'h0, 11'd3, 11'd5, 11'd6);       // rank above range
    send_request(rks_pkg::FUNC_QUERY, 16'h0, 11'h7FF, 11'h7FF, 11'h7FF);
    drain();

    in_idle_pct  = 11;
    out_idle_pct = 80;
    random_phase(650);
    drain();

    in_idle_pct  = 80;
    out_idle_pct = 11;
    random_phase(650);
    drain();

    // no idling; long receiver hold-off first so the input backs up
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_off     = 400;
    random_phase(500);
    // make sure the store-full path is hit
    while (order_sb.stored() < MAX_ELEMS)
      random_append();
    for (int i = 0; i < 10; i++)
      random_append();
    for (int i = 0; i < 30; i++) random_query();
    drain();
    repeat (100) @(posedge clk);
    if (order_sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
